// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked check that also covers the reset cycles
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/hsl_pkg.sv -----
`default_nettype none

package hsl_pkg;

  localparam int HueCircle  = 1536;
  localparam int HueThird   = 21;
  localparam int ChanOffset = 512;
  localparam int RiseEnd    = 256;
  localparam int HighEnd    = 768;
  localparam int FallEnd    = 1024;
  localparam int DivBase    = 255;
  localparam int RoundDiv   = 127;
  localparam int RoundRamp  = 128;
  localparam int LightHalf  = 128;
  localparam int PosW       = 11;

  typedef logic [PosW-1:0] hue_pos_t;

  typedef struct packed {
    logic [5:0] hue;
    logic [7:0] saturation;
    logic [7:0] lightness;
  } hsl_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_word_t;

  // stage loads handed from the top level to each channel
  typedef struct packed {
    logic load_mul;
    logic load_out;
  } hsl_ctl_t;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  // floor(k * 512 / 21) for one third of the circle
  function automatic logic [9:0] hue_base(input logic [4:0] k);
    logic [9:0] r;
    case (k)
      5'd0:    r = 10'd0;
      5'd1:    r = 10'd24;
      5'd2:    r = 10'd48;
      5'd3:    r = 10'd73;
      5'd4:    r = 10'd97;
      5'd5:    r = 10'd121;
      5'd6:    r = 10'd146;
      5'd7:    r = 10'd170;
      5'd8:    r = 10'd195;
      5'd9:    r = 10'd219;
      5'd10:   r = 10'd243;
      5'd11:   r = 10'd268;
      5'd12:   r = 10'd292;
      5'd13:   r = 10'd316;
      5'd14:   r = 10'd341;
      5'd15:   r = 10'd365;
      5'd16:   r = 10'd390;
      5'd17:   r = 10'd414;
      5'd18:   r = 10'd438;
      5'd19:   r = 10'd463;
      5'd20:   r = 10'd487;
      5'd21:   r = 10'd512;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // hue * 1536 / 63, split into thirds of 21 steps each
  function automatic hue_pos_t hue_pos(input logic [5:0] h);
    hue_pos_t r;
    if (h >= 6'(2 * HueThird)) begin
      r = hue_pos_t'(2 * ChanOffset) + hue_pos_t'(hue_base(5'(h - 6'(2 * HueThird))));
    end else if (h >= 6'(HueThird)) begin
      r = hue_pos_t'(ChanOffset) + hue_pos_t'(hue_base(5'(h - 6'(HueThird))));
    end else begin
      r = hue_pos_t'(hue_base(5'(h)));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hsl_chan.sv -----
`default_nettype none

module hsl_chan (
  input  wire                   clk,
  input  wire hsl_pkg::hsl_ctl_t ctl,
  input  wire hsl_pkg::hue_pos_t pos,
  input  wire [7:0]             p_base,
  input  wire [7:0]             span,
  output logic [7:0]            value
);
  import hsl_pkg::*;

  seg_t        seg;
  logic [8:0]  weight;
  logic [16:0] prod;

  seg_t        seg_m;
  logic [16:0] prod_m;
  logic [7:0]  p_m;
  logic [7:0]  span_m;

  logic [8:0]  ramp;
  logic [8:0]  level;
  logic [7:0]  value_next;

  // segment of the curve and ramp weight
  always_comb begin
    if (pos < hue_pos_t'(RiseEnd)) begin
      seg    = SEG_RISE;
      weight = 9'(pos);
    end else if (pos < hue_pos_t'(HighEnd)) begin
      seg    = SEG_HIGH;
      weight = 9'd0;
    end else if (pos < hue_pos_t'(FallEnd)) begin
      seg    = SEG_FALL;
      weight = 9'(hue_pos_t'(FallEnd) - pos);
    end else begin
      seg    = SEG_LOW;
      weight = 9'd0;
    end
  end

  assign prod = 17'(span) * 17'(weight);

  always_ff @(posedge clk) begin
    if (ctl.load_mul) begin
      seg_m  <= seg;
      prod_m <= prod;
      p_m    <= p_base;
      span_m <= span;
    end
  end

  assign ramp = 9'((prod_m + 17'(RoundRamp)) >> 8);

  always_comb begin
    case (seg_m)
      SEG_RISE: level = 9'(p_m) + ramp;
      SEG_FALL: level = 9'(p_m) + ramp;
      SEG_HIGH: level = 9'(p_m) + 9'(span_m);
      SEG_LOW:  level = 9'(p_m);
      default:  level = 9'(p_m);
    endcase
    value_next = level[8] ? 8'hFF : level[7:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      value <= value_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hsl_to_rgb_converter.sv -----
`default_nettype none

// HSL to RGB pixel converter: a four-stage pipeline that takes one pixel
// word per clock and gives one RGB word per clock while out_ready is high;
// a word taken into stage one passes stages two and three and shows on
// out_valid from stage four. Stage one forms the lightness product for q
// and p on one shared 8x9 multiplier and looks up the hue position, stage
// two divides by 255 and places each channel on the hue circle, stage three
// runs one 8x9 ramp multiplier per channel, and stage four rounds, selects
// the curve segment and clamps. Each stage holds a valid bit and moves on
// whenever the stage after it is empty or moving, so bubbles close up;
// in_ready drops only when all four stages are full and out_ready is low.
module hsl_to_rgb_converter (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire hsl_pkg::hsl_word_t in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output hsl_pkg::rgb_word_t     out_data
);
  import hsl_pkg::*;

  logic v1, v2, v3, v4;
  logic rdy2, rdy3, rdy4;
  logic adv1, adv2, adv3, adv4;
  hsl_ctl_t ctl;

  // stage one
  logic       lo0;
  logic [8:0] mul_b0;
  logic [15:0] x0;
  logic [15:0] x1;
  hue_pos_t   t1;
  logic [7:0] l1, s1;
  logic       lo1;

  // stage two
  logic [8:0] quo;
  logic [9:0] q_full, p_full;
  logic [11:0] red_sum;
  hue_pos_t   pos_r, pos_g, pos_b;
  hue_pos_t   pos2 [3];
  logic [7:0] p2, d2;

  logic [7:0] chan_val [3];

  // handshake chain
  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign in_ready = !v1 || rdy2;

  assign adv1 = in_valid && in_ready;
  assign adv2 = v1 && rdy2;
  assign adv3 = v2 && rdy3;
  assign adv4 = v3 && rdy4;

  assign ctl.load_mul = adv3;
  assign ctl.load_out = adv4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= 1'b1;
      end else if (adv2) begin
        v1 <= 1'b0;
      end
      if (adv2) begin
        v2 <= 1'b1;
      end else if (adv3) begin
        v2 <= 1'b0;
      end
      if (adv3) begin
        v3 <= 1'b1;
      end else if (adv4) begin
        v3 <= 1'b0;
      end
      if (adv4) begin
        v4 <= 1'b1;
      end else if (out_ready) begin
        v4 <= 1'b0;
      end
    end
  end

  // l*(255+s) for dark pixels, l*s otherwise, plus the rounding term
  always_comb begin
    lo0    = in_data.lightness < 8'(LightHalf);
    mul_b0 = lo0 ? 9'(DivBase) + 9'(in_data.saturation) : 9'(in_data.saturation);
    x0     = 16'(17'(in_data.lightness) * 17'(mul_b0) + 17'(RoundDiv));
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      x1  <= x0;
      t1  <= hue_pos(in_data.hue);
      l1  <= in_data.lightness;
      s1  <= in_data.saturation;
      lo1 <= lo0;
    end
  end

  // exact x/255 for 16-bit x below 65535: (x + 1 + (x >> 8)) >> 8
  always_comb begin
    quo    = 9'((17'(x1) + 17'd1 + 17'(x1[15:8])) >> 8);
    q_full = lo1 ? 10'(quo) : 10'(l1) + 10'(s1) - 10'(quo);
    p_full = {1'b0, l1, 1'b0} - q_full;

    red_sum = 12'(t1) + 12'(ChanOffset);
    pos_r = (red_sum >= 12'(HueCircle)) ? hue_pos_t'(red_sum - 12'(HueCircle))
                                         : hue_pos_t'(red_sum);
    pos_g = (t1 >= hue_pos_t'(HueCircle)) ? hue_pos_t'(0) : t1;
    pos_b = (t1 < hue_pos_t'(ChanOffset)) ? t1 + hue_pos_t'(HueCircle - ChanOffset)
                                           : t1 - hue_pos_t'(ChanOffset);
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      pos2[0] <= pos_r;
      pos2[1] <= pos_g;
      pos2[2] <= pos_b;
      p2      <= p_full[7:0];
      d2      <= 8'(q_full - p_full);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_chan
    hsl_chan u_chan (
      .clk    (clk),
      .ctl    (ctl),
      .pos    (pos2[i]),
      .p_base (p2),
      .span   (d2),
      .value  (chan_val[i])
    );
  end

  assign out_valid      = v4;
  assign out_data.red   = chan_val[0];
  assign out_data.green = chan_val[1];
  assign out_data.blue  = chan_val[2];

endmodule

`default_nettype wire

// ----- rtl/hsl_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module hsl_checker (
  input wire                    clk,
  input wire                    rst,
  input wire                    in_valid,
  input wire                    in_ready,
  input wire hsl_pkg::hsl_word_t in_data,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire hsl_pkg::rgb_word_t out_data
);

  logic acc;
  logic gray_acc;
  logic gray_ok;

  assign acc      = in_valid && in_ready;
  assign gray_acc = acc && (in_data.saturation == 8'd0);
  assign gray_ok  = (out_data.green == out_data.red) && (out_data.blue == out_data.red);

  // a gray word comes out as its lightness on all three channels
  property p_gray;
    gray_acc ##1 out_ready ##1 out_ready ##1 out_ready
      |=> gray_ok && out_data.red == $past(in_data.lightness, 4);
  endproperty

  `ASSERT_RST(a_reset_empty, rst |=> !out_valid && in_ready, "pipeline not empty after reset")

  `ASSERT_CLK(a_backpressure, !in_ready |-> out_valid && !out_ready, "input stalled without cause")

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "word lost")

  `ASSERT_CLK(a_latency, acc ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid, "word late")

  `ASSERT_CLK(a_gray, p_gray, "gray pixel wrong")

endmodule

bind hsl_to_rgb_converter hsl_checker u_checker (.*);

`default_nettype wire

// ----- tb/sv/hsl_rgb_checker.sv -----
`timescale 1ns / 100ps

// watches both channels, predicts each rgb word and compares it in order
module hsl_rgb_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  hsl_pkg::hsl_word_t in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  hsl_pkg::rgb_word_t out_data,
  output int                 errors,
  output int                 pending
);
  import hsl_pkg::*;

  typedef struct {
    hsl_word_t pixel;
    rgb_word_t rgb;
  } rgb_due_t;

  rgb_due_t rgb_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // level of the hsl curve at one position of the 1536-step circle
  function automatic logic [7:0] curve_level(input int p, input int q, input int pos);
    int w;
    int v;
    w = pos;
    while (w < 0) w += HueCircle;
    while (w >= HueCircle) w -= HueCircle;
    if (w < RiseEnd) begin
      v = p + ((q - p) * w + RoundRamp) / RiseEnd;
    end else if (w < HighEnd) begin
      v = q;
    end else if (w < FallEnd) begin
      v = p + ((q - p) * (FallEnd - w) + RoundRamp) / RiseEnd;
    end else begin
      v = p;
    end
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic rgb_word_t rgb_of(input hsl_word_t px);
    rgb_word_t r;
    int h;
    int s;
    int l;
    int q;
    int p;
    int t;
    h = int'(px.hue);
    s = int'(px.saturation);
    l = int'(px.lightness);
    if (s == 0) begin
      r.red   = px.lightness;
      r.green = px.lightness;
      r.blue  = px.lightness;
    end else begin
      if (l < LightHalf) q = (l * (DivBase + s) + RoundDiv) / DivBase;
      else q = l + s - (l * s + RoundDiv) / DivBase;
      p = 2 * l - q;
      t = (h * HueCircle) / 63;
      r.red   = curve_level(p, q, t + ChanOffset);
      r.green = curve_level(p, q, t);
      r.blue  = curve_level(p, q, t - ChanOffset);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rgb_due_t head;
    rgb_due_t fresh;
    if (!rst) begin
      if (in_valid && in_ready) begin
        fresh.pixel = in_data;
        fresh.rgb   = rgb_of(in_data);
        rgb_due.push_back(fresh);
      end
      if (out_valid && out_ready) begin
        if (rgb_due.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("unexpected rgb word r=%0d g=%0d b=%0d",
                     out_data.red, out_data.green, out_data.blue);
        end else begin
          head = rgb_due.pop_front();
          if (out_data.red !== head.rgb.red || out_data.green !== head.rgb.green ||
              out_data.blue !== head.rgb.blue) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch h=%0d s=%0d l=%0d: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       head.pixel.hue, head.pixel.saturation, head.pixel.lightness,
                       head.rgb.red, head.rgb.green, head.rgb.blue,
                       out_data.red, out_data.green, out_data.blue);
          end
        end
      end
      pending = rgb_due.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import hsl_pkg::*;

  localparam int CycleLimit = 200000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  hsl_word_t in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rgb_word_t out_data;
  int        errors;
  int        pending;
  int        cycles = 0;
  int        send_gap_pct = 33;
  int        stall_pct = 33;

  always #6 clk = ~clk;

  hsl_to_rgb_converter uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  hsl_rgb_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_pixel(input logic [5:0] h, input logic [7:0] s, input logic [7:0] l);
    hsl_word_t w;
    w.hue        = h;
    w.saturation = s;
    w.lightness  = l;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // mostly uniform, with gray pixels and the lightness and saturation edges favored
  task automatic send_random_pixel();
    logic [7:0] s;
    logic [7:0] l;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) s = 8'd0;
    else if (pick < 20) s = 8'd255;
    else s = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 4) l = 8'd0;
    else if (pick < 8) l = 8'd255;
    else if (pick < 12) l = 8'd127;
    else if (pick < 16) l = 8'd128;
    else l = 8'($urandom_range(255));
    send_pixel(6'($urandom_range(63)), s, l);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes, thirds of the circle, gray pixels, lightness around the q split
    send_pixel(6'd0, 8'd0, 8'd0);
    send_pixel(6'd63, 8'd255, 8'd255);
    send_pixel(6'd0, 8'd255, 8'd128);
    send_pixel(6'd63, 8'd255, 8'd128);
    send_pixel(6'd21, 8'd255, 8'd128);
    send_pixel(6'd42, 8'd255, 8'd128);
    send_pixel(6'd20, 8'd255, 8'd128);
    send_pixel(6'd41, 8'd255, 8'd128);
    send_pixel(6'd0, 8'd0, 8'd200);
    send_pixel(6'd63, 8'd0, 8'd77);
    send_pixel(6'd5, 8'd0, 8'd255);
    send_pixel(6'd10, 8'd255, 8'd127);
    send_pixel(6'd11, 8'd1, 8'd128);
    send_pixel(6'd32, 8'd128, 8'd64);
    send_pixel(6'd53, 8'd200, 8'd255);
    send_pixel(6'd1, 8'd255, 8'd0);
    send_pixel(6'd62, 8'd170, 8'd1);
    send_pixel(6'd31, 8'd85, 8'd254);
    send_pixel(6'd16, 8'd255, 8'd255);
    send_pixel(6'd48, 8'd1, 8'd1);

    repeat (400) send_random_pixel();

    // hold off until the pipe has drained completely
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    send_gap_pct = 0;
    stall_pct    = 0;
    repeat (200) send_random_pixel();

    send_gap_pct = 33;
    stall_pct    = 33;
    repeat (350) send_random_pixel();

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
